// File: sv/tli_pkg.sv
// shared types, constants and codes of the table linear interpolator
package tli_pkg;

  localparam int POINTS     = 64;
  localparam int COLUMNS    = 4;
  localparam int IDX_W      = $clog2(POINTS);
  localparam int COL_W      = 2;
  localparam int VAL_AW     = $clog2(POINTS * COLUMNS);
  localparam int PCNT_W     = 7;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // largest quotient magnitude kept before the final add
  localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    REQ_WR_X = 2'd0,
    REQ_WR_Y = 2'd1,
    REQ_EVAL = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT = 2'd0,
    CFG_PERIODIC    = 2'd1,
    CFG_PERIOD_LOW  = 2'd2,
    CFG_PERIOD_HIGH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         point_index;
    logic [1:0]         column_index;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_column;
    logic signed [31:0] out_value;
    logic               last_column;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WRAP, S_WWAIT, S_WFIX, S_RX0, S_RXL, S_CLS,
    S_HRD, S_HDIR, S_DRD, S_DCHK, S_URD, S_UCHK,
    S_XA, S_XB, S_SEG, S_COL, S_YA, S_YB, S_MUL, S_DIV, S_DWAIT, S_FIN, S_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_WRAP_LO, OP_WRAP_HI, OP_WRAP_FIX,
    OP_RD_X0, OP_RD_XL, OP_CLASSIFY, OP_RD_I, OP_HUNT_DIR, OP_DN_CHK, OP_UP_CHK,
    OP_RD_XA, OP_RD_XB, OP_SEG, OP_RD_YA, OP_YA, OP_YB, OP_MUL, OP_DIV_START,
    OP_FIN, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap_lo;
    logic wrap_hi;
    logic div_done;
    logic clamp;
    logic hunt_up;
    logic dn_more;
    logic up_more;
    logic interp;
    logic dx_pos;
    logic out_free;
    logic last_col;
  } dp_status_t;

endpackage

// File: sv/tli_ram.sv
// generic single write port ram with registered read
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/tli_div.sv
// restoring divider, one quotient bit per cycle
module tli_div import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic [63:0]          dq_r;
  logic [31:0]          rem_r;
  logic [31:0]          dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [32:0]          trial;
  logic                 ge;

  // shift in next dividend bit and compare
  always_comb begin
    trial = {rem_r, dq_r[63]};
    ge    = trial >= {1'b0, dvs_r};
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[62:0], ge};
      rem_r <= ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
    end
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

// File: sv/tli_ctrl.sv
// sequencing state machine of the interpolator
module tli_ctrl import tli_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_eval,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       in_stall
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (in_eval) state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (st.wrap_lo) begin
          cmd.op    = OP_WRAP_LO;
          state_nxt = S_WWAIT;
        end else if (st.wrap_hi) begin
          cmd.op    = OP_WRAP_HI;
          state_nxt = S_WWAIT;
        end else begin
          state_nxt = S_RX0;
        end
      end
      S_WWAIT: if (st.div_done) state_nxt = S_WFIX;
      S_WFIX: begin
        cmd.op    = OP_WRAP_FIX;
        state_nxt = S_RX0;
      end
      S_RX0: begin
        cmd.op    = OP_RD_X0;
        state_nxt = S_RXL;
      end
      S_RXL: begin
        cmd.op    = OP_RD_XL;
        state_nxt = S_CLS;
      end
      S_CLS: begin
        cmd.op    = OP_CLASSIFY;
        state_nxt = st.clamp ? S_COL : S_HRD;
      end
      S_HRD: begin
        cmd.op    = OP_RD_I;
        state_nxt = S_HDIR;
      end
      S_HDIR: begin
        cmd.op = OP_HUNT_DIR;
        if (st.hunt_up)      state_nxt = S_URD;
        else if (st.dn_more) state_nxt = S_DRD;
        else                 state_nxt = S_XA;
      end
      S_DRD: begin
        cmd.op    = OP_RD_I;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        cmd.op    = OP_DN_CHK;
        state_nxt = st.dn_more ? S_DRD : S_XA;
      end
      S_URD: begin
        cmd.op    = OP_RD_I;
        state_nxt = S_UCHK;
      end
      S_UCHK: begin
        cmd.op    = OP_UP_CHK;
        state_nxt = st.up_more ? S_URD : S_XA;
      end
      S_XA: begin
        cmd.op    = OP_RD_XA;
        state_nxt = S_XB;
      end
      S_XB: begin
        cmd.op    = OP_RD_XB;
        state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.op    = OP_SEG;
        state_nxt = S_COL;
      end
      S_COL: begin
        cmd.op    = OP_RD_YA;
        state_nxt = S_YA;
      end
      S_YA: begin
        cmd.op    = OP_YA;
        state_nxt = st.interp ? S_YB : S_OUT;
      end
      S_YB: begin
        cmd.op    = OP_YB;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = st.dx_pos ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.op    = OP_DIV_START;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: if (st.div_done) state_nxt = S_FIN;
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = st.last_col ? S_IDLE : S_COL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  // divider completes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_WWAIT || state_r == S_DWAIT))
    else $error("divider done outside a wait state");
`endif

endmodule

// File: sv/tli_dp.sv
// datapath: tables, config registers, hunt, interpolation and output register
module tli_dp import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  st,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  // configuration
  logic [PCNT_W-1:0]  point_count_r;
  logic               periodic_r;
  logic signed [31:0] period_low_r;
  logic signed [31:0] period_high_r;

  // evaluation state
  logic [IDX_W-1:0]   cache_r, i_r, row_r;
  logic [COL_W-1:0]   col_r;
  logic               interp_r;
  logic               wrap_hi_r;
  logic signed [31:0] q_r, x0_r, xa_r, ya_r, result_r;
  logic signed [32:0] dx_r, dy_r;
  logic [31:0]        t_r, p_r;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // ram and divider hookup
  logic [31:0]        bp_rdata, val_rdata;
  logic signed [31:0] bp_x, val_y;
  logic [IDX_W-1:0]   bp_raddr;
  logic [VAL_AW-1:0]  val_raddr;
  logic               bp_we, val_we;
  logic [VAL_AW-1:0]  val_waddr;
  logic               div_start, div_done;
  logic [63:0]        div_dividend, div_quot;
  logic [31:0]        div_divisor, div_rem;

  // derived values
  logic [IDX_W-1:0]   nm1;
  logic               wrap_on;
  logic signed [32:0] per_diff, d_lo, d_hi;
  logic [31:0]        dy_abs;
  logic [63:0]        prod;
  logic [40:0]        mag;
  logic signed [42:0] sum;
  logic signed [31:0] sum_sat;
  logic signed [32:0] fix_lo, fix_hi;

  assign bp_x  = $signed(bp_rdata);
  assign val_y = $signed(val_rdata);

  // last active row index from the saturated point count
  always_comb begin
    if (point_count_r < PCNT_W'(2))           nm1 = IDX_W'(1);
    else if (point_count_r > PCNT_W'(POINTS)) nm1 = IDX_W'(POINTS - 1);
    else                                      nm1 = IDX_W'(point_count_r - PCNT_W'(1));
  end

  // periodic window arithmetic
  always_comb begin
    per_diff = {period_high_r[31], period_high_r} - {period_low_r[31], period_low_r};
    d_lo     = {period_low_r[31], period_low_r} - {q_r[31], q_r};
    d_hi     = {q_r[31], q_r} - {period_high_r[31], period_high_r};
    wrap_on  = periodic_r && (period_high_r > period_low_r);
    fix_lo   = {period_low_r[31], period_low_r} + {1'b0, p_r} - {1'b0, div_rem};
    fix_hi   = {period_high_r[31], period_high_r} - {1'b0, p_r} + {1'b0, div_rem};
  end

  // multiply and final saturating add
  always_comb begin
    dy_abs  = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
    prod    = t_r * dy_abs;
    mag     = (div_quot > 64'(QUOT_CAP)) ? QUOT_CAP : div_quot[40:0];
    sum     = neg_r ? (43'(ya_r) - $signed({2'b00, mag}))
                    : (43'(ya_r) + $signed({2'b00, mag}));
    if (sum > 43'sd2147483647)       sum_sat = 32'sh7fff_ffff;
    else if (sum < -43'sd2147483648) sum_sat = 32'sh8000_0000;
    else                             sum_sat = sum[31:0];
  end

  // status to the controller
  always_comb begin
    st.wrap_lo  = wrap_on && (q_r < period_low_r);
    st.wrap_hi  = wrap_on && (q_r > period_high_r);
    st.div_done = div_done;
    st.clamp    = (q_r <= x0_r) || (q_r >= bp_x);
    st.hunt_up  = q_r > bp_x;
    st.dn_more  = (i_r != '0) && (q_r < bp_x);
    st.up_more  = (i_r < nm1) && (q_r > bp_x);
    st.interp   = interp_r;
    st.dx_pos   = !dx_r[32] && (dx_r != '0);
    st.out_free = !out_valid_r || !out_stall;
    st.last_col = col_r == COL_W'(COLUMNS - 1);
  end

  // table writes and read address selection
  always_comb begin
    bp_we     = (cmd.op == OP_LOAD) && (in_data.req_type == REQ_WR_X)
                && (int'(in_data.point_index) < POINTS);
    val_we    = (cmd.op == OP_LOAD) && (in_data.req_type == REQ_WR_Y)
                && (int'(in_data.point_index) < POINTS)
                && (int'(in_data.column_index) < COLUMNS);
    val_waddr = VAL_AW'(int'(in_data.point_index) * COLUMNS + int'(in_data.column_index));
    bp_raddr  = '0;
    val_raddr = VAL_AW'(int'(row_r) * COLUMNS + int'(col_r));
    case (cmd.op)
      OP_RD_XL: bp_raddr = nm1;
      OP_RD_I:  bp_raddr = i_r;
      OP_RD_XA: bp_raddr = row_r;
      OP_RD_XB: bp_raddr = row_r + 1'b1;
      OP_YA:    val_raddr = VAL_AW'((int'(row_r) + 1) * COLUMNS + int'(col_r));
      default:  bp_raddr = '0;
    endcase
  end

  // divider operand selection
  always_comb begin
    div_start    = (cmd.op == OP_WRAP_LO) || (cmd.op == OP_WRAP_HI)
                   || (cmd.op == OP_DIV_START);
    div_divisor  = (cmd.op == OP_DIV_START) ? dx_r[31:0] : per_diff[31:0];
    case (cmd.op)
      OP_WRAP_LO: div_dividend = {32'b0, d_lo[31:0]};
      OP_WRAP_HI: div_dividend = {32'b0, d_hi[31:0]};
      default:    div_dividend = prod_r;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PCNT_W'(2);
      periodic_r    <= 1'b0;
      period_low_r  <= 32'sd0;
      period_high_r <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POINT_COUNT: point_count_r <= cfg_data[PCNT_W-1:0];
        CFG_PERIODIC:    periodic_r    <= cfg_data[0];
        CFG_PERIOD_LOW:  period_low_r  <= $signed(cfg_data);
        CFG_PERIOD_HIGH: period_high_r <= $signed(cfg_data);
        default:         periodic_r    <= periodic_r;
      endcase
    end
  end

  // segment index, cache and column control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_r  <= '0;
      i_r      <= '0;
      row_r    <= '0;
      col_r    <= '0;
      interp_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: col_r <= '0;
        OP_CLASSIFY: begin
          if (q_r <= x0_r) begin
            row_r    <= '0;
            cache_r  <= '0;
            interp_r <= 1'b0;
          end else if (q_r >= bp_x) begin
            row_r    <= nm1;
            cache_r  <= nm1;
            interp_r <= 1'b0;
          end else begin
            i_r      <= (cache_r > nm1) ? nm1 : cache_r;
            interp_r <= 1'b1;
          end
        end
        OP_HUNT_DIR: begin
          if (st.hunt_up) begin
            i_r <= i_r + 1'b1;
          end else if (st.dn_more) begin
            i_r <= i_r - 1'b1;
          end else begin
            row_r   <= i_r;
            cache_r <= i_r;
          end
        end
        OP_DN_CHK: begin
          if (st.dn_more) begin
            i_r <= i_r - 1'b1;
          end else begin
            row_r   <= i_r;
            cache_r <= i_r;
          end
        end
        OP_UP_CHK: begin
          if (st.up_more) begin
            i_r <= i_r + 1'b1;
          end else begin
            row_r   <= i_r - 1'b1;
            cache_r <= i_r - 1'b1;
          end
        end
        OP_EMIT: col_r <= col_r + 1'b1;
        default: col_r <= col_r;
      endcase
    end
  end

  // arithmetic payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:    q_r <= in_data.data_value;
      OP_WRAP_LO: begin
        wrap_hi_r <= 1'b0;
        p_r       <= per_diff[31:0];
      end
      OP_WRAP_HI: begin
        wrap_hi_r <= 1'b1;
        p_r       <= per_diff[31:0];
      end
      OP_WRAP_FIX: begin
        if (div_rem == '0) q_r <= wrap_hi_r ? period_high_r : period_low_r;
        else               q_r <= wrap_hi_r ? fix_hi[31:0] : fix_lo[31:0];
      end
      OP_RD_XL: x0_r <= bp_x;
      OP_RD_XB: xa_r <= bp_x;
      OP_SEG: begin
        dx_r <= {bp_x[31], bp_x} - {xa_r[31], xa_r};
        t_r  <= 32'(q_r - xa_r);
      end
      OP_YA: begin
        ya_r     <= val_y;
        result_r <= val_y;
      end
      OP_YB:  dy_r <= {val_y[31], val_y} - {ya_r[31], ya_r};
      OP_MUL: begin
        prod_r <= prod;
        neg_r  <= dy_r[32];
      end
      OP_FIN:  result_r <= sum_sat;
      default: neg_r <= neg_r;
    endcase
  end

  // result register toward the output channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_data_r.out_column  <= col_r;
      out_data_r.out_value   <= result_r;
      out_data_r.last_column <= st.last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tli_ram #(.WIDTH(32), .DEPTH(POINTS)) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (in_data.point_index[IDX_W-1:0]),
    .wdata (in_data.data_value),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  tli_ram #(.WIDTH(32), .DEPTH(POINTS * COLUMNS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (in_data.data_value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

`ifndef SYNTH
  // an interpolated segment always has a following row
  a_seg_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SEG) |-> (row_r < nm1))
    else $error("segment row beyond last interval");

  // result register fills only on an emit command
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_EMIT))
    else $error("result raised without emit");

  // no new result while an old one is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

// File: sv/table_linear_interpolator_top.sv
// top level of the table linear interpolator
// Breakpoint and value write transactions are taken in the idle state and
// never stall the input. An evaluate transaction either clamps the query to
// an end row or, when it falls inside the table, hunts for its segment from
// the cached one, stepping over one breakpoint at a time. After that each
// column of a clamped query is read and emitted directly. An interpolated
// column goes through the registered table reads and the 64 step serial
// divider (one quotient bit per cycle). A segment of zero or negative width
// skips the divider. A periodic wrap also runs through the same divider.
// No new transaction is taken until the last column of an evaluation has
// been loaded into the output register.
module table_linear_interpolator_top import tli_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eval  (in_data.req_type == REQ_EVAL),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the table linear interpolator, with its own predictor
module tb_top;
  import tli_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int HOLD_CYCLES  = 900;
  localparam int TAIL_CYCLES  = 60;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_POINT_COUNT;
  logic [31:0] cfg_data = '0;

  table_linear_interpolator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pending requests and the interpolated values they should yield
  in_item_t  req_q[$];
  out_item_t interp_q[$];
  int        errors = 0;
  bit        idling_on = 1'b1;
  bit        hold_start = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        cycle_cnt = 0;
  out_item_t want;

  // predictor copy of table, cache and registers
  logic [31:0] x_tab[POINTS];
  logic [31:0] y_tab[POINTS*COLUMNS];
  int unsigned seg_cache = 0;
  logic [6:0]  pcnt = 7'd2;
  logic        wrap_en = 1'b0;
  longint      win_lo = 0;
  longint      win_hi = 65536;

  // breakpoints as the generator last queued them
  logic [31:0] gen_x[POINTS];

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // interpolation predictor, run on every accepted request
  function automatic void interpolate(in_item_t it);
    longint q, p, y0, x0, dx, dy, t, v, m;
    int unsigned n, i, row, c;
    bit interp, neg;
    logic [127:0] prod, quo;
    logic [63:0] mt, md;
    out_item_t r;
    interp = 1'b0;
    case (it.req_type)
      REQ_WR_X: x_tab[it.point_index] = it.data_value;
      REQ_WR_Y: y_tab[it.point_index*COLUMNS + it.column_index] = it.data_value;
      REQ_EVAL: begin
        q = sx(it.data_value);
        // fold the query into the periodic window
        if (wrap_en && win_hi > win_lo) begin
          p = win_hi - win_lo;
          if (q < win_lo) q += p * ((win_lo - q + p - 1) / p);
          if (q > win_hi) q -= p * ((q - win_hi + p - 1) / p);
        end
        n = (pcnt < 2) ? 2 : ((pcnt > POINTS) ? POINTS : pcnt);
        i = (seg_cache > n - 1) ? n - 1 : seg_cache;
        // clamp to end rows or hunt from the cached segment
        if (q <= sx(x_tab[0])) begin
          row = 0;
          seg_cache = 0;
        end else if (q >= sx(x_tab[n-1])) begin
          row = n - 1;
          seg_cache = n - 1;
        end else begin
          if (q <= sx(x_tab[i])) begin
            while (i > 0 && q < sx(x_tab[i])) i--;
          end else begin
            do i++; while (i < n - 1 && q > sx(x_tab[i]));
            i--;
          end
          row = i;
          seg_cache = i;
          interp = 1'b1;
        end
        for (c = 0; c < COLUMNS; c++) begin
          y0 = sx(y_tab[row*COLUMNS + c]);
          v = y0;
          if (interp) begin
            x0 = sx(x_tab[row]);
            dx = sx(x_tab[row+1]) - x0;
            dy = sx(y_tab[(row+1)*COLUMNS + c]) - y0;
            t = q - x0;
            if (dx > 0) begin
              neg = (t < 0) != (dy < 0);
              mt = (t < 0) ? -t : t;
              md = (dy < 0) ? -dy : dy;
              prod = {64'd0, mt} * {64'd0, md};
              quo = prod / {64'd0, dx};
              m = (quo > (128'd1 << 40)) ? (64'sd1 <<< 40) : longint'(quo[63:0]);
              v = neg ? y0 - m : y0 + m;
            end
          end
          v = clamp32(v);
          r.out_column = c[1:0];
          r.out_value = v[31:0];
          r.last_column = (c == COLUMNS - 1);
          interp_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // driver: offers queued requests, holds a stalled transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) interpolate(in_data);
      if (!in_valid || !in_stall) begin
        if (req_q.size() > 0 && !(idling_on && $urandom_range(0, 99) < 31)) begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction and drives stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (interp_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: actual col=%0d val=%0d last=%0b", $time,
                   out_data.out_column, out_data.out_value, out_data.last_column);
        end else begin
          want = interp_q.pop_front();
          if (out_data.out_column !== want.out_column) begin
            errors++;
            $display("%0t out_column: expected %0d actual %0d", $time,
                     want.out_column, out_data.out_column);
          end
          if (out_data.out_value !== want.out_value) begin
            errors++;
            $display("%0t out_value: expected %0d actual %0d", $time,
                     want.out_value, out_data.out_value);
          end
          if (out_data.last_column !== want.last_column) begin
            errors++;
            $display("%0t last_column: expected %0b actual %0b", $time,
                     want.last_column, out_data.last_column);
          end
        end
      end
      if (hold_start && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idling_on && ($urandom_range(0, 99) < 31);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_POINT_COUNT: pcnt = val[6:0];
      CFG_PERIODIC:    wrap_en = val[0];
      CFG_PERIOD_LOW:  win_lo = sx(val);
      CFG_PERIOD_HIGH: win_hi = sx(val);
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [6:0] n, bit md, logic [31:0] lo, logic [31:0] hi);
    write_reg(CFG_POINT_COUNT, {25'd0, n});
    write_reg(CFG_PERIODIC, {31'd0, md});
    write_reg(CFG_PERIOD_LOW, lo);
    write_reg(CFG_PERIOD_HIGH, hi);
  endtask

  // wait for the block to drain, checked away from the driving edge
  task automatic drain();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || interp_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic push_req(req_t kind, int unsigned row, int unsigned col, logic [31:0] val);
    in_item_t it;
    it.req_type = kind;
    it.point_index = row[5:0];
    it.column_index = col[1:0];
    it.data_value = val;
    if (kind == REQ_WR_X) gen_x[row] = val;
    req_q.push_back(it);
  endtask

  function automatic logic [31:0] near_point(int unsigned n);
    longint v;
    v = sx(gen_x[$urandom_range(0, n - 1)]) + longint'($urandom_range(0, 131072)) - 65536;
    v = clamp32(v);
    return v[31:0];
  endfunction

  // random mix: mostly well-formed table edits and evaluations
  task automatic random_traffic(int count, int unsigned n);
    int k, sel, row;
    longint lo, hi, v;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      row = $urandom_range(0, POINTS - 1);
      if (sel < 12) begin
        lo = (row > 0) ? sx(gen_x[row-1]) + 1 : S32_MIN;
        hi = (row < POINTS - 1) ? sx(gen_x[row+1]) - 1 : S32_MAX;
        if (lo <= hi) begin
          v = lo + longint'($urandom_range(0, 32'(hi - lo)));
          push_req(REQ_WR_X, row, 0, v[31:0]);
        end else begin
          push_req(REQ_WR_X, row, 0, $urandom);
        end
      end else if (sel < 16) begin
        push_req(REQ_WR_X, row, $urandom_range(0, 3), $urandom);
      end else if (sel < 36) begin
        push_req(REQ_WR_Y, row, $urandom_range(0, 3), $urandom);
      end else if (sel < 39) begin
        push_req(req_t'(2'd3), row, $urandom_range(0, 3), $urandom);
      end else if (sel < 80) begin
        push_req(REQ_EVAL, $urandom_range(0, 63), $urandom_range(0, 3), near_point(n));
      end else begin
        push_req(REQ_EVAL, $urandom_range(0, 63), $urandom_range(0, 3), $urandom);
      end
    end
  endtask

  initial begin
    int r, c;
    longint xv;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole table with increasing breakpoints
    xv = -64'sd1073741824;
    for (r = 0; r < POINTS; r++) begin
      xv += $urandom_range(1, 1 << 25);
      push_req(REQ_WR_X, r, 0, xv[31:0]);
      for (c = 0; c < COLUMNS; c++) push_req(REQ_WR_Y, r, c, $urandom);
    end

    // directed: clamps, exact points, extremes, saturation, flat segment
    push_req(REQ_EVAL, 0, 0, gen_x[0] - 1);
    push_req(REQ_EVAL, 0, 0, gen_x[0]);
    push_req(REQ_EVAL, 63, 3, gen_x[0] + 1);
    push_req(REQ_EVAL, 0, 0, gen_x[1]);
    push_req(REQ_EVAL, 0, 0, gen_x[1] + 1);
    push_req(REQ_EVAL, 0, 0, 32'h8000_0000);
    push_req(REQ_EVAL, 0, 0, 32'h7fff_ffff);
    push_req(REQ_WR_Y, 0, 3, 32'h7fff_ffff);
    push_req(REQ_WR_Y, 1, 3, 32'h8000_0000);
    push_req(REQ_WR_Y, 0, 0, 32'h8000_0000);
    push_req(REQ_WR_Y, 1, 0, 32'h7fff_ffff);
    push_req(REQ_EVAL, 0, 0, gen_x[1] - 1);
    push_req(REQ_EVAL, 0, 0, gen_x[0] + 3);
    push_req(req_t'(2'd3), 63, 3, 32'hffff_ffff);
    push_req(REQ_WR_Y, 63, 3, 32'h0000_0000);
    push_req(REQ_WR_X, 1, 0, gen_x[0]);
    push_req(REQ_EVAL, 0, 0, gen_x[0] + 1);
    push_req(REQ_WR_X, 1, 0, gen_x[0] + 32'd5000);
    push_req(REQ_EVAL, 0, 0, gen_x[0] + 32'd2500);
    drain();

    // full table, receiver held off to back up the block
    configure(7'd64, 1'b0, 32'd0, 32'd65536);
    hold_start = 1'b1;
    random_traffic(25, 64);
    drain();

    // short table with a window inside it
    configure(7'd8, 1'b1, gen_x[1], gen_x[6]);
    random_traffic(15, 8);
    drain();

    // count below range, widest window
    configure(7'd0, 1'b1, 32'h8000_0000, 32'h7fff_ffff);
    random_traffic(10, 2);
    drain();

    // count above range, window not positive
    configure(7'd127, 1'b1, 32'd5, 32'hffff_fffb);
    random_traffic(10, 64);
    drain();

    // no idling on either side
    idling_on = 1'b0;
    configure(7'd64, 1'b1, gen_x[10], gen_x[40]);
    random_traffic(20, 64);
    drain();
    idling_on = 1'b1;

    configure(7'd33, 1'b0, 32'd0, 32'd65536);
    random_traffic(10, 33);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
